/* hdl/kbf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_pkg: shared definitions for the angle and gyro bias Kalman filter
// Widths, reset values, sequencer codes and the saturation helper.
// ----------------------------------------------------------------------------
package kbf_pkg;

   localparam int WORD_BITS     = 32;
   localparam int COV_FRAC_BITS = 28;
   localparam int CFG_BITS      = 31;
   localparam int GAIN_BITS     = 8;
   localparam int OPND_BITS     = WORD_BITS + 1;
   localparam int PROD_BITS     = 2 * OPND_BITS;
   localparam int WIDE_BITS     = PROD_BITS + 2;
   localparam int NUM_BITS      = WORD_BITS + COV_FRAC_BITS;
   localparam int DIV_CNT_BITS  = $clog2(NUM_BITS);
   localparam int CSR_IDX_BITS  = 3;

   localparam logic [CFG_BITS-1:0] APN_RESET =
      CFG_BITS'((64'd1 << COV_FRAC_BITS) / 64'd1000);
   localparam logic [CFG_BITS-1:0] BPN_RESET =
      CFG_BITS'((64'd3 << COV_FRAC_BITS) / 64'd1000);
   localparam logic [CFG_BITS-1:0] MNOISE_RESET =
      CFG_BITS'(64'd1 << (COV_FRAC_BITS - 1));
   localparam logic [CFG_BITS-1:0] DT_RESET =
      CFG_BITS'((64'd1 << COV_FRAC_BITS) / 64'd1000);
   localparam logic signed [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1);
   localparam logic signed [WORD_BITS-1:0] COV_ONE =
      WORD_BITS'(64'd1 << COV_FRAC_BITS);

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WRITE,
      ST_DSTART,
      ST_DWAIT,
      ST_FIN
   } state_type;

   typedef enum logic [4:0] {
      OP_ANG,
      OP_P00,
      OP_P01,
      OP_P10,
      OP_P11,
      OP_PC0,
      OP_PC1,
      OP_T1,
      OP_DEN,
      OP_K0,
      OP_K1,
      OP_UAA,
      OP_UAB,
      OP_UBA,
      OP_UBB,
      OP_UA,
      OP_UB
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_APN    = 3'd0,
      CSR_BPN    = 3'd1,
      CSR_MNOISE = 3'd2,
      CSR_DT     = 3'd3,
      CSR_GAIN   = 3'd4
   } csr_type;

   function automatic word_type sat_word(input logic signed [WIDE_BITS-1:0] x);
      logic [WIDE_BITS-WORD_BITS:0] top;
      top = x[WIDE_BITS-1:WORD_BITS-1];
      if (top == '0 || top == '1) begin
         return x[WORD_BITS-1:0];
      end else if (x[WIDE_BITS-1]) begin
         return {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(WORD_BITS-1){1'b1}}};
      end
   endfunction

endpackage

/* hdl/kbf_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_mul: shared signed multiplier
// One registered 33 by 33 bit signed product per cycle.
// ----------------------------------------------------------------------------
module kbf_mul (
   input  logic                                    clock,
   input  logic signed [kbf_pkg::OPND_BITS-1:0]    mul_a,
   input  logic signed [kbf_pkg::OPND_BITS-1:0]    mul_b,
   output logic signed [kbf_pkg::PROD_BITS-1:0]    prod_ff
);

   logic signed [kbf_pkg::PROD_BITS-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* hdl/kbf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_div: iterative gain divider
// Computes sat32((num * 2^28) / den), truncated toward zero, one quotient bit
// per cycle. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module kbf_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  kbf_pkg::word_type           num,
   input  kbf_pkg::word_type           den,
   output logic                        done,
   output kbf_pkg::word_type           quo
);

   localparam int NB = kbf_pkg::NUM_BITS;
   localparam int WB = kbf_pkg::WORD_BITS;
   localparam logic [kbf_pkg::DIV_CNT_BITS-1:0] CNT_LAST =
      kbf_pkg::DIV_CNT_BITS'(NB - 1);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [kbf_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [WB-1:0]                    rem_ff, rem_in;
   logic [WB-1:0]                    mag_ff, mag_in;
   logic [NB-1:0]                    dq_ff, dq_in;
   logic                             neg_ff, neg_in;
   logic                             zero_ff, zero_in;

   logic [WB:0]   trial;
   logic [WB:0]   diff;
   logic          ge;
   logic [WB-1:0] num_mag;

   assign trial   = {rem_ff, dq_ff[NB-1]};
   assign diff    = trial - {1'b0, mag_ff};
   assign ge      = trial >= {1'b0, mag_ff};
   assign num_mag = num[WB-1] ? WB'(-num) : num;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      mag_in  = mag_ff;
      dq_in   = dq_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dq_in   = {num_mag, {kbf_pkg::COV_FRAC_BITS{1'b0}}};
         mag_in  = den[WB-1] ? WB'(-den) : den;
         neg_in  = num[WB-1] ^ den[WB-1];
         zero_in = (den == '0);
      end else if (busy_ff) begin
         rem_in = ge ? diff[WB-1:0] : trial[WB-1:0];
         dq_in  = {dq_ff[NB-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      mag_ff  <= mag_in;
      dq_ff   <= dq_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      if (zero_ff) begin
         quo = '0;
      end else if (neg_ff) begin
         if (dq_ff[NB-1:WB] != '0 || (dq_ff[WB-1] && dq_ff[WB-2:0] != '0)) begin
            quo = {1'b1, {(WB-1){1'b0}}};
         end else begin
            quo = -dq_ff[WB-1:0];
         end
      end else begin
         if (dq_ff[NB-1:WB-1] != '0) begin
            quo = {1'b0, {(WB-1){1'b1}}};
         end else begin
            quo = dq_ff[WB-1:0];
         end
      end
   end

   assign done = done_ff;

endmodule

/* hdl/angle_bias_kalman_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter: two-state Kalman filter for tilt angle and bias
// Each req transaction carries an accelerometer angle and a gyro rate in
// Q16.16; each rsp transaction returns the updated angle, the gyro bias and
// the bias-corrected rate, all Q16.16 and saturated. Covariance is Q4.28; the
// noise terms and the sample period are unsigned Q3.28.
// The csr port writes the noise terms, the sample period and the observation
// gain; write it only while no transaction is in progress.
// A sequencer drives one shared registered multiplier, one saturating write-back
// adder and a one-bit-per-cycle divider. Each item runs 15 multiply and
// write-back pairs (ISSUE then WRITE), two gain divisions (DSTART then DWAIT)
// and a final load of the output register.
// req_tready is high only while the block is idle, so a new item is accepted
// only after the last one has left the sequencer. A result waits in the
// output register while rsp_tready is low; a new item is accepted meanwhile,
// and its result is held back until the previous one is taken.
// Synchronous reset restores the default registers, zero angle and bias and
// unit covariance diagonal.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // accel_angle [31:0], gyro_rate [63:32]
   input  logic [63:0]                         req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // angle_estimate [31:0], bias_estimate [63:32], corrected_rate [95:64]
   output logic [95:0]                         rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [kbf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [kbf_pkg::CFG_BITS-1:0]        csr_wr_data
);

   localparam int WB = kbf_pkg::WORD_BITS;
   localparam int OB = kbf_pkg::OPND_BITS;
   localparam int PB = kbf_pkg::PROD_BITS;
   localparam int XB = kbf_pkg::WIDE_BITS;
   localparam int CB = kbf_pkg::CFG_BITS;
   localparam int GB = kbf_pkg::GAIN_BITS;

   kbf_pkg::state_type state_ff, state_in;
   kbf_pkg::op_type    op_ff, op_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [CB-1:0]          apn_ff, apn_in, bpn_ff, bpn_in;
   logic [CB-1:0]          mnoise_ff, mnoise_in, dt_ff, dt_in;
   logic signed [GB-1:0]   gain_ff, gain_in;

   kbf_pkg::word_type angle_ff, angle_in, bias_ff, bias_in;
   kbf_pkg::word_type caa_ff, caa_in, cab_ff, cab_in;
   kbf_pkg::word_type cba_ff, cba_in, cbb_ff, cbb_in;
   kbf_pkg::word_type meas_ff, meas_in, rate_ff, rate_in, err_ff, err_in;
   kbf_pkg::word_type pc0_ff, pc0_in, pc1_ff, pc1_in, t1_ff, t1_in;
   kbf_pkg::word_type den_ff, den_in, k0_ff, k0_in, k1_ff, k1_in;
   logic [95:0]       out_ff, out_in;

   logic signed [OB-1:0] mul_a, mul_b;
   logic signed [PB-1:0] prod;
   logic                 div_start, div_done;
   kbf_pkg::word_type    div_quo, div_num;
   logic                 out_free;

   logic signed [XB-1:0] wb_base, wb_term, wb_sum;
   logic signed [PB-1:0] term_p;
   logic                 wb_shift, wb_neg;
   kbf_pkg::word_type    wb_val;
   kbf_pkg::word_type    rb_sat, d00_sat, err_sat, corr_sat;
   logic signed [OB-1:0] gain_x, dt_x;

   kbf_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   kbf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign gain_x  = {{(OB-GB){gain_ff[GB-1]}}, gain_ff};
   assign dt_x    = {{(OB-CB){1'b0}}, dt_ff};
   assign rb_sat  = kbf_pkg::sat_word(XB'(rate_ff) - XB'(bias_ff));
   assign d00_sat = kbf_pkg::sat_word(XB'(signed'({1'b0, apn_ff}))
                                      - XB'(cab_ff) - XB'(cba_ff));
   assign err_sat  = kbf_pkg::sat_word(XB'(meas_ff) - XB'(angle_ff));
   assign corr_sat = kbf_pkg::sat_word(XB'(rate_ff) - XB'(bias_ff));
   assign div_num  = (op_ff == kbf_pkg::OP_K0) ? pc0_ff : pc1_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         kbf_pkg::OP_ANG: begin mul_a = OB'(rb_sat);  mul_b = dt_x; end
         kbf_pkg::OP_P00: begin mul_a = OB'(d00_sat); mul_b = dt_x; end
         kbf_pkg::OP_P01,
         kbf_pkg::OP_P10: begin mul_a = -OB'(cbb_ff); mul_b = dt_x; end
         kbf_pkg::OP_P11: begin
            mul_a = OB'(signed'({1'b0, bpn_ff}));
            mul_b = dt_x;
         end
         kbf_pkg::OP_PC0: begin mul_a = gain_x; mul_b = OB'(caa_ff); end
         kbf_pkg::OP_PC1: begin mul_a = gain_x; mul_b = OB'(cba_ff); end
         kbf_pkg::OP_T1:  begin mul_a = gain_x; mul_b = OB'(cab_ff); end
         kbf_pkg::OP_DEN: begin mul_a = gain_x; mul_b = OB'(pc0_ff); end
         kbf_pkg::OP_UAA: begin mul_a = OB'(k0_ff); mul_b = OB'(pc0_ff); end
         kbf_pkg::OP_UAB: begin mul_a = OB'(k0_ff); mul_b = OB'(t1_ff); end
         kbf_pkg::OP_UBA: begin mul_a = OB'(k1_ff); mul_b = OB'(pc0_ff); end
         kbf_pkg::OP_UBB: begin mul_a = OB'(k1_ff); mul_b = OB'(t1_ff); end
         kbf_pkg::OP_UA:  begin mul_a = OB'(k0_ff); mul_b = OB'(err_ff); end
         kbf_pkg::OP_UB:  begin mul_a = OB'(k1_ff); mul_b = OB'(err_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      wb_base  = '0;
      wb_shift = 1'b1;
      wb_neg   = 1'b0;
      case (op_ff)
         kbf_pkg::OP_ANG: wb_base = XB'(angle_ff);
         kbf_pkg::OP_P00: wb_base = XB'(caa_ff);
         kbf_pkg::OP_P01: wb_base = XB'(cab_ff);
         kbf_pkg::OP_P10: wb_base = XB'(cba_ff);
         kbf_pkg::OP_P11: wb_base = XB'(cbb_ff);
         kbf_pkg::OP_PC0,
         kbf_pkg::OP_PC1,
         kbf_pkg::OP_T1:  wb_shift = 1'b0;
         kbf_pkg::OP_DEN: begin
            wb_base  = XB'(signed'({1'b0, mnoise_ff}));
            wb_shift = 1'b0;
         end
         kbf_pkg::OP_UAA: begin wb_base = XB'(caa_ff);   wb_neg = 1'b1; end
         kbf_pkg::OP_UAB: begin wb_base = XB'(cab_ff);   wb_neg = 1'b1; end
         kbf_pkg::OP_UBA: begin wb_base = XB'(cba_ff);   wb_neg = 1'b1; end
         kbf_pkg::OP_UBB: begin wb_base = XB'(cbb_ff);   wb_neg = 1'b1; end
         kbf_pkg::OP_UA:  wb_base = XB'(angle_ff);
         kbf_pkg::OP_UB:  wb_base = XB'(bias_ff);
         default: wb_base = '0;
      endcase
   end

   assign term_p  = wb_shift ? (prod >>> kbf_pkg::COV_FRAC_BITS) : prod;
   assign wb_term = XB'(term_p);
   assign wb_sum  = wb_neg ? (wb_base - wb_term) : (wb_base + wb_term);
   assign wb_val  = kbf_pkg::sat_word(wb_sum);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         kbf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = kbf_pkg::ST_ISSUE;
               op_in    = kbf_pkg::OP_ANG;
            end
         end
         kbf_pkg::ST_ISSUE: state_in = kbf_pkg::ST_WRITE;
         kbf_pkg::ST_WRITE: begin
            if (op_ff == kbf_pkg::OP_DEN) begin
               state_in = kbf_pkg::ST_DSTART;
               op_in    = kbf_pkg::OP_K0;
            end else if (op_ff == kbf_pkg::OP_UB) begin
               state_in = kbf_pkg::ST_FIN;
            end else begin
               state_in = kbf_pkg::ST_ISSUE;
               op_in    = kbf_pkg::op_type'(op_ff + 5'd1);
            end
         end
         kbf_pkg::ST_DSTART: state_in = kbf_pkg::ST_DWAIT;
         kbf_pkg::ST_DWAIT: begin
            if (div_done) begin
               if (op_ff == kbf_pkg::OP_K0) begin
                  state_in = kbf_pkg::ST_DSTART;
                  op_in    = kbf_pkg::OP_K1;
               end else begin
                  state_in = kbf_pkg::ST_ISSUE;
                  op_in    = kbf_pkg::OP_UAA;
               end
            end
         end
         kbf_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = kbf_pkg::ST_IDLE;
            end
         end
         default: state_in = kbf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == kbf_pkg::ST_IDLE);
      div_start  = (state_ff == kbf_pkg::ST_DSTART);
      out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      apn_in = apn_ff;       bpn_in = bpn_ff;
      mnoise_in = mnoise_ff; dt_in = dt_ff;   gain_in = gain_ff;
      angle_in = angle_ff;   bias_in = bias_ff;
      caa_in = caa_ff; cab_in = cab_ff; cba_in = cba_ff; cbb_in = cbb_ff;
      meas_in = meas_ff; rate_in = rate_ff; err_in = err_ff;
      pc0_in = pc0_ff; pc1_in = pc1_ff; t1_in = t1_ff;
      den_in = den_ff; k0_in = k0_ff; k1_in = k1_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_wr_en) begin
         case (csr_index)
            kbf_pkg::CSR_APN:    apn_in    = csr_wr_data;
            kbf_pkg::CSR_BPN:    bpn_in    = csr_wr_data;
            kbf_pkg::CSR_MNOISE: mnoise_in = csr_wr_data;
            kbf_pkg::CSR_DT:     dt_in     = csr_wr_data;
            kbf_pkg::CSR_GAIN:   gain_in   = csr_wr_data[GB-1:0];
            default: apn_in = apn_ff;
         endcase
      end

      if (state_ff == kbf_pkg::ST_IDLE && req_tvalid) begin
         meas_in = req_tdata[WB-1:0];
         rate_in = req_tdata[2*WB-1:WB];
      end

      if (state_ff == kbf_pkg::ST_WRITE) begin
         case (op_ff)
            kbf_pkg::OP_ANG: angle_in = wb_val;
            kbf_pkg::OP_P00: caa_in   = wb_val;
            kbf_pkg::OP_P01: cab_in   = wb_val;
            kbf_pkg::OP_P10: cba_in   = wb_val;
            kbf_pkg::OP_P11: cbb_in   = wb_val;
            kbf_pkg::OP_PC0: begin
               pc0_in = wb_val;
               err_in = err_sat;
            end
            kbf_pkg::OP_PC1: pc1_in   = wb_val;
            kbf_pkg::OP_T1:  t1_in    = wb_val;
            kbf_pkg::OP_DEN: den_in   = wb_val;
            kbf_pkg::OP_UAA: caa_in   = wb_val;
            kbf_pkg::OP_UAB: cab_in   = wb_val;
            kbf_pkg::OP_UBA: cba_in   = wb_val;
            kbf_pkg::OP_UBB: cbb_in   = wb_val;
            kbf_pkg::OP_UA:  angle_in = wb_val;
            kbf_pkg::OP_UB:  bias_in  = wb_val;
            default: angle_in = angle_ff;
         endcase
      end

      if (state_ff == kbf_pkg::ST_DWAIT && div_done) begin
         if (op_ff == kbf_pkg::OP_K0) begin
            k0_in = div_quo;
         end else begin
            k1_in = div_quo;
         end
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == kbf_pkg::ST_FIN && out_free) begin
         out_in       = {corr_sat, bias_ff, angle_ff};
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kbf_pkg::ST_IDLE;
         op_ff        <= kbf_pkg::OP_ANG;
         rsp_valid_ff <= 1'b0;
         apn_ff       <= kbf_pkg::APN_RESET;
         bpn_ff       <= kbf_pkg::BPN_RESET;
         mnoise_ff    <= kbf_pkg::MNOISE_RESET;
         dt_ff        <= kbf_pkg::DT_RESET;
         gain_ff      <= kbf_pkg::GAIN_RESET;
         angle_ff     <= '0;
         bias_ff      <= '0;
         caa_ff       <= kbf_pkg::COV_ONE;
         cab_ff       <= '0;
         cba_ff       <= '0;
         cbb_ff       <= kbf_pkg::COV_ONE;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         apn_ff       <= apn_in;
         bpn_ff       <= bpn_in;
         mnoise_ff    <= mnoise_in;
         dt_ff        <= dt_in;
         gain_ff      <= gain_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         caa_ff       <= caa_in;
         cab_ff       <= cab_in;
         cba_ff       <= cba_in;
         cbb_ff       <= cbb_in;
      end
      meas_ff <= meas_in;
      rate_ff <= rate_in;
      err_ff  <= err_in;
      pc0_ff  <= pc0_in;
      pc1_ff  <= pc1_in;
      t1_ff   <= t1_in;
      den_ff  <= den_in;
      k0_ff   <= k0_in;
      k1_ff   <= k1_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule
